// ----- sv/gfs_pkg.sv -----
// Shared constants and types for the gaze fixation smoother.
// Used by gfs_mul, gaze_fixation_smoother and the sim files; depends on nothing.
`default_nettype none

package gfs_pkg;

    localparam int WINDOW = 4;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CLOG_W = $clog2(WINDOW);
    localparam int RAW_W  = 12;
    localparam int POS_W  = 16;
    localparam int SUM_W  = RAW_W + CLOG_W;
    localparam int NUM_W  = SUM_W + 4;
    localparam int MUL_W  = NUM_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 2 * POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int WGT_W  = 9;
    localparam int Q8     = 8;

    localparam int RECIP_SHIFT = NUM_W + CLOG_W;
    localparam logic [63:0] RECIP_POW  = 64'd1 << RECIP_SHIFT;
    localparam logic [63:0] RECIP_FULL = (RECIP_POW + 64'(WINDOW) - 64'd1) / WINDOW;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;

    localparam logic [POS_W-1:0] RADIUS_RESET = 16'd480;
    localparam logic [WGT_W-1:0] WEIGHT_RESET = 9'd230;
    localparam logic [WGT_W-1:0] WEIGHT_ONE   = 9'd256;

    typedef logic [MUL_W-1:0]  mul_op_t;
    typedef logic [PROD_W-1:0] mul_prod_t;

endpackage

`default_nettype wire

// ----- sv/gfs_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on gfs_pkg for operand and product widths.
`default_nettype none

module gfs_mul (
    input  wire logic               clk,
    input  wire gfs_pkg::mul_op_t   mul_a,
    input  wire gfs_pkg::mul_op_t   mul_b,
    output gfs_pkg::mul_prod_t      prod
);
    import gfs_pkg::*;

    mul_prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- sv/gaze_fixation_smoother.sv -----
// Top level of the gaze fixation smoother: ring window, sequencer, output register.
// Depends on gfs_pkg and gfs_mul.
//
// Usage:
//   in channel  (in_valid/in_ready, gaze_x, gaze_y): one raw gaze sample per transfer.
//   out channel (out_valid/out_ready, smooth_x, smooth_y, is_fixation): one result
//     per input sample, smoothed point in 1/16 pixel.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes the
//     dispersion radius, index 1 the Q8 smoothing weight; other indexes are dropped.
//     cfg_ready is always high; write only while no sample is in flight.
//   Each sample walks the window twice, with one shared multiplier for all products:
//   the sum, then the radius square and the two means, then the dispersion test point
//   by point, and the blend when the sample is a fixation.
//   out_valid rises together with in_ready when the sequencer leaves its output step,
//   so the next sample can be taken while the result waits.
//   A finished result waits in the output register; the next sample is taken and
//   processed meanwhile, and the sequencer holds only when it has a new result and
//   the old one is still not taken.
//   Reset clears the window, the held point and the fixation history to zero and
//   loads radius 480 and weight 230.
`default_nettype none

module gaze_fixation_smoother (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [gfs_pkg::RAW_W-1:0]       gaze_x,
    input  wire logic [gfs_pkg::RAW_W-1:0]       gaze_y,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [gfs_pkg::POS_W-1:0]            smooth_x,
    output logic [gfs_pkg::POS_W-1:0]            smooth_y,
    output logic                                 is_fixation,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gfs_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import gfs_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_SUM  = 15'b000000000000010,
        ST_RSQ  = 15'b000000000000100,
        ST_MNX  = 15'b000000000001000,
        ST_MNY  = 15'b000000000010000,
        ST_MNC  = 15'b000000000100000,
        ST_DSX  = 15'b000000001000000,
        ST_DSY  = 15'b000000010000000,
        ST_DCMP = 15'b000000100000000,
        ST_BLX0 = 15'b000001000000000,
        ST_BLX1 = 15'b000010000000000,
        ST_BLY0 = 15'b000100000000000,
        ST_BLY1 = 15'b001000000000000,
        ST_BLC  = 15'b010000000000000,
        ST_OUT  = 15'b100000000000000
    } state_t;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [NUM_W-1:0]  NUM_HALF  = NUM_W'(WINDOW / 2);
    localparam logic [ACC_W-1:0]  ROUND_Q8  = ACC_W'(128);
    localparam mul_op_t           RECIP     = RECIP_FULL[MUL_W-1:0];

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [RAW_W-1:0]      win_x_reg [WINDOW];
    logic [RAW_W-1:0]      win_y_reg [WINDOW];
    logic                  win_we;
    logic [RAW_W-1:0]      raw_x_reg, raw_y_reg;
    logic [SUM_W-1:0]      sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [SQ_W-1:0]       r2_reg, r2_next;
    logic [POS_W-1:0]      mean_x_reg, mean_x_next, mean_y_reg, mean_y_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  fix_reg, fix_next;
    logic                  was_fix_reg, was_fix_next;
    logic [POS_W-1:0]      held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic [POS_W-1:0]      radius_reg, radius_next;
    logic [WGT_W-1:0]      weight_reg, weight_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic [POS_W-1:0]      smooth_x_reg, smooth_y_reg;
    logic                  fix_out_reg;

    mul_op_t               mul_a, mul_b;
    mul_prod_t             prod;

    logic [WGT_W-1:0]      w_sat, w_rest;
    logic [POS_W-1:0]      pt_x, pt_y, dist_x, dist_y;
    logic [POS_W-1:0]      base_x, base_y;
    logic [ACC_W-1:0]      acc_plus, blend_full;
    logic                  outside;
    logic [NUM_W-1:0]      num_x, num_y;

    gfs_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign w_sat  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_rest = WEIGHT_ONE - w_sat;

    assign pt_x   = {win_x_reg[idx_reg], 4'b0000};
    assign pt_y   = {win_y_reg[idx_reg], 4'b0000};
    assign dist_x = (pt_x >= mean_x_reg) ? (pt_x - mean_x_reg) : (mean_x_reg - pt_x);
    assign dist_y = (pt_y >= mean_y_reg) ? (pt_y - mean_y_reg) : (mean_y_reg - pt_y);

    assign base_x = was_fix_reg ? held_x_reg : mean_x_reg;
    assign base_y = was_fix_reg ? held_y_reg : mean_y_reg;

    assign num_x  = {sum_x_reg, 4'b0000} + NUM_HALF;
    assign num_y  = {sum_y_reg, 4'b0000} + NUM_HALF;

    assign acc_plus   = acc_reg + prod[ACC_W-1:0];
    assign blend_full = acc_plus + ROUND_Q8;
    assign outside    = acc_plus > {1'b0, r2_reg};

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign smooth_x    = smooth_x_reg;
    assign smooth_y    = smooth_y_reg;
    assign is_fixation = fix_out_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RSQ:
            begin
                mul_a = MUL_W'(radius_reg);
                mul_b = MUL_W'(radius_reg);
            end
            ST_MNX:
            begin
                mul_a = MUL_W'(num_x);
                mul_b = RECIP;
            end
            ST_MNY:
            begin
                mul_a = MUL_W'(num_y);
                mul_b = RECIP;
            end
            ST_DSX:
            begin
                mul_a = MUL_W'(dist_x);
                mul_b = MUL_W'(dist_x);
            end
            ST_DSY:
            begin
                mul_a = MUL_W'(dist_y);
                mul_b = MUL_W'(dist_y);
            end
            ST_BLX0:
            begin
                mul_a = MUL_W'(base_x);
                mul_b = MUL_W'(w_sat);
            end
            ST_BLX1:
            begin
                mul_a = MUL_W'({raw_x_reg, 4'b0000});
                mul_b = MUL_W'(w_rest);
            end
            ST_BLY0:
            begin
                mul_a = MUL_W'(base_y);
                mul_b = MUL_W'(w_sat);
            end
            ST_BLY1:
            begin
                mul_a = MUL_W'({raw_y_reg, 4'b0000});
                mul_b = MUL_W'(w_rest);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        win_we         = 1'b0;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        r2_next        = r2_reg;
        mean_x_next    = mean_x_reg;
        mean_y_next    = mean_y_reg;
        acc_next       = acc_reg;
        fix_next       = fix_reg;
        was_fix_next   = was_fix_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    win_we     = 1'b1;
                    slot_next  = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    idx_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_x_next = sum_x_reg + SUM_W'(win_x_reg[idx_reg]);
                sum_y_next = sum_y_reg + SUM_W'(win_y_reg[idx_reg]);
                if (idx_reg == SLOT_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_RSQ;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RSQ:
            begin
                state_next = ST_MNX;
            end
            ST_MNX:
            begin
                r2_next    = prod[SQ_W-1:0];
                state_next = ST_MNY;
            end
            ST_MNY:
            begin
                mean_x_next = prod[RECIP_SHIFT +: POS_W];
                state_next  = ST_MNC;
            end
            ST_MNC:
            begin
                mean_y_next = prod[RECIP_SHIFT +: POS_W];
                fix_next    = 1'b1;
                state_next  = ST_DSX;
            end
            ST_DSX:
            begin
                state_next = ST_DSY;
            end
            ST_DSY:
            begin
                acc_next   = ACC_W'(prod[SQ_W-1:0]);
                state_next = ST_DCMP;
            end
            ST_DCMP:
            begin
                fix_next = fix_reg && !outside;
                if (idx_reg == SLOT_LAST)
                begin
                    idx_next   = '0;
                    state_next = (fix_reg && !outside) ? ST_BLX0 : ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DSX;
                end
            end
            ST_BLX0:
            begin
                state_next = ST_BLX1;
            end
            ST_BLX1:
            begin
                acc_next   = ACC_W'(prod[SQ_W-1:0]);
                state_next = ST_BLY0;
            end
            ST_BLY0:
            begin
                held_x_next = blend_full[Q8 +: POS_W];
                state_next  = ST_BLY1;
            end
            ST_BLY1:
            begin
                acc_next   = ACC_W'(prod[SQ_W-1:0]);
                state_next = ST_BLC;
            end
            ST_BLC:
            begin
                held_y_next = blend_full[Q8 +: POS_W];
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    was_fix_next   = fix_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        radius_next = radius_reg;
        weight_next = weight_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS: radius_next = cfg_data;
                CFG_WEIGHT: weight_next = cfg_data[WGT_W-1:0];
                default:    radius_next = radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            slot_reg      <= '0;
            fix_reg       <= 1'b0;
            was_fix_reg   <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            radius_reg    <= RADIUS_RESET;
            weight_reg    <= WEIGHT_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            fix_reg       <= fix_next;
            was_fix_reg   <= was_fix_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            radius_reg    <= radius_next;
            weight_reg    <= weight_next;
            out_valid_reg <= out_valid_next;
            if (win_we)
            begin
                win_x_reg[slot_reg] <= gaze_x;
                win_y_reg[slot_reg] <= gaze_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_x_reg  <= sum_x_next;
        sum_y_reg  <= sum_y_next;
        r2_reg     <= r2_next;
        mean_x_reg <= mean_x_next;
        mean_y_reg <= mean_y_next;
        acc_reg    <= acc_next;
        if (win_we)
        begin
            raw_x_reg <= gaze_x;
            raw_y_reg <= gaze_y;
        end
        if (out_load)
        begin
            smooth_x_reg <= held_x_reg;
            smooth_y_reg <= held_y_reg;
            fix_out_reg  <= fix_reg;
        end
    end

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an input transfer");

    a_idle_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (idx_reg == '0))
        else $error("window index not cleared while idle");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result presented outside the output step");

    a_blend_only_on_fixation: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLX0) |-> fix_reg)
        else $error("blend started without a fixation");

endmodule

`default_nettype wire

// ----- sim/gfs_result_checker.sv -----
// Result checker for the gaze fixation smoother: watches the sample, result and register
// channels, predicts each smoothed point and fixation flag, and counts mismatches.
// Depends on gfs_pkg.
module gfs_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [gfs_pkg::RAW_W-1:0]     gaze_x,
    input  logic [gfs_pkg::RAW_W-1:0]     gaze_y,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [gfs_pkg::POS_W-1:0]     smooth_x,
    input  logic [gfs_pkg::POS_W-1:0]     smooth_y,
    input  logic                          is_fixation,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [gfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gfs_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            failures,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gfs_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             fix;
    } smoothed_point_t;

    smoothed_point_t  smoothed_q[$];
    logic [RAW_W-1:0] ring_x [WINDOW];
    logic [RAW_W-1:0] ring_y [WINDOW];
    int unsigned      ring_slot;
    logic [POS_W-1:0] held_x;
    logic [POS_W-1:0] held_y;
    logic             in_fixation;
    logic [POS_W-1:0] radius;
    logic [WGT_W-1:0] weight;

    function automatic logic [POS_W-1:0] exp_blend(int unsigned old, int unsigned raw,
                                                   int unsigned w);
        int unsigned v;
        v = (old * w + raw * 16 * (256 - w) + 128) >> Q8;
        return v[POS_W-1:0];
    endfunction

    function automatic int unsigned axis_gap(int unsigned a, int unsigned b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic absorb_sample(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
        int unsigned     sum_x;
        int unsigned     sum_y;
        int unsigned     mean_x;
        int unsigned     mean_y;
        int unsigned     dx;
        int unsigned     dy;
        int unsigned     w;
        longint unsigned r2;
        longint unsigned d2;
        logic            fix;
        smoothed_point_t res;
        ring_x[ring_slot] = x;
        ring_y[ring_slot] = y;
        sum_x = 0;
        sum_y = 0;
        for (int i = 0; i < WINDOW; i++)
        begin
            sum_x += ring_x[i];
            sum_y += ring_y[i];
        end
        mean_x = (sum_x * 16 + WINDOW / 2) / WINDOW;
        mean_y = (sum_y * 16 + WINDOW / 2) / WINDOW;
        r2 = 64'(radius) * 64'(radius);
        fix = 1'b1;
        for (int i = 0; i < WINDOW; i++)
        begin
            dx = axis_gap(32'(ring_x[i]) * 16, mean_x);
            dy = axis_gap(32'(ring_y[i]) * 16, mean_y);
            d2 = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
            if (d2 > r2)
                fix = 1'b0;
        end
        ring_slot = (ring_slot + 1) % WINDOW;
        w = (weight > WEIGHT_ONE) ? 32'(WEIGHT_ONE) : 32'(weight);
        if (fix && !in_fixation)
        begin
            held_x = mean_x[POS_W-1:0];
            held_y = mean_y[POS_W-1:0];
        end
        if (fix)
        begin
            held_x = exp_blend(held_x, x, w);
            held_y = exp_blend(held_y, y, w);
        end
        in_fixation = fix;
        res.x = held_x;
        res.y = held_y;
        res.fix = fix;
        smoothed_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_x[i] = '0;
                ring_y[i] = '0;
            end
            ring_slot = 0;
            held_x = '0;
            held_y = '0;
            in_fixation = 1'b0;
            radius = RADIUS_RESET;
            weight = WEIGHT_RESET;
            smoothed_q.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RADIUS: radius = cfg_data[POS_W-1:0];
                    CFG_WEIGHT: weight = cfg_data[WGT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (smoothed_q.size() == 0)
                begin
                    $error("result transfer with no sample outstanding");
                    failures++;
                end
                else
                begin
                    smoothed_point_t want;
                    want = smoothed_q.pop_front();
                    if (smooth_x !== want.x)
                    begin
                        $error("smooth_x mismatch: expected %0d, actual %0d", want.x, smooth_x);
                        failures++;
                    end
                    if (smooth_y !== want.y)
                    begin
                        $error("smooth_y mismatch: expected %0d, actual %0d", want.y, smooth_y);
                        failures++;
                    end
                    if (is_fixation !== want.fix)
                    begin
                        $error("is_fixation mismatch: expected %0d, actual %0d",
                               want.fix, is_fixation);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_sample(gaze_x, gaze_y);
            pending = smoothed_q.size();
        end
    end

endmodule

// ----- sim/gaze_fixation_smoother_tb.sv -----
// Testbench top for the gaze fixation smoother: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on gfs_pkg,
// gaze_fixation_smoother and gfs_result_checker.
module gaze_fixation_smoother_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 55;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 4 * WINDOW + 20;
    localparam int RAW_MAX      = (1 << RAW_W) - 1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [RAW_W-1:0]     gaze_x;
    logic [RAW_W-1:0]     gaze_y;
    logic                 out_valid;
    logic                 out_ready;
    logic [POS_W-1:0]     smooth_x;
    logic [POS_W-1:0]     smooth_y;
    logic                 is_fixation;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    int                   failures;
    int                   pending;

    int send_idle;
    int recv_idle;
    int sent_count;
    int hold_left;
    bit hold_done;

    gaze_fixation_smoother DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .gaze_x      (gaze_x),
        .gaze_y      (gaze_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .smooth_x    (smooth_x),
        .smooth_y    (smooth_y),
        .is_fixation (is_fixation),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    gfs_result_checker fixation_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .gaze_x      (gaze_x),
        .gaze_y      (gaze_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .smooth_x    (smooth_x),
        .smooth_y    (smooth_y),
        .is_fixation (is_fixation),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        gaze_x = '0;
        gaze_y = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        sent_count = 0;
        hold_left = 0;
        hold_done = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold while samples keep coming.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_sample(int x, int y);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        gaze_x <= x[RAW_W-1:0];
        gaze_y <= y[RAW_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Drain the block before touching its registers.
    task automatic program_regs(logic [CFG_DAT_W-1:0] radius, logic [CFG_DAT_W-1:0] wdata,
                                bit poke_spare);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        put_reg(CFG_RADIUS, radius);
        put_reg(CFG_WEIGHT, wdata);
        if (poke_spare)
        begin
            put_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
            put_reg(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int jitter(int c, int spread);
        int off;
        int v;
        off = $urandom_range(0, 2 * spread);
        v = c + off - spread;
        if (v < 0)
            v = 0;
        if (v > RAW_MAX)
            v = RAW_MAX;
        return v;
    endfunction

    task automatic random_settings();
        logic [CFG_DAT_W-1:0] radius;
        logic [CFG_DAT_W-1:0] wdata;
        int                   pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: radius = '0;
            1: radius = '1;
            2: radius = 16'($urandom_range(0, 65535));
            default: radius = 16'($urandom_range(16, 1200));
        endcase
        wdata = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        case (pick)
            0: wdata[WGT_W-1:0] = '0;
            1: wdata[WGT_W-1:0] = WEIGHT_ONE;
            2: wdata[WGT_W-1:0] = 9'($urandom_range(257, 511));
            default: wdata[WGT_W-1:0] = 9'($urandom_range(0, 255));
        endcase
        program_regs(radius, wdata, $urandom_range(0, 3) == 0);
    endtask

    // Mostly dwell runs around a point, broken up by jumps, corners and slow drift.
    task automatic random_samples(int count);
        int left;
        int kind;
        int cx;
        int cy;
        int spread;
        int len;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            cx = $urandom_range(0, RAW_MAX);
            cy = $urandom_range(0, RAW_MAX);
            case ($urandom_range(0, 5))
                0: spread = 0;
                1: spread = 1;
                2: spread = 2;
                3: spread = 4;
                4: spread = 8;
                default: spread = 32;
            endcase
            len = $urandom_range(3, 12);
            if (len > left)
                len = left;
            if (kind <= 6)
            begin
                for (int i = 0; i < len; i++)
                    send_sample(jitter(cx, spread), jitter(cy, spread));
                left -= len;
            end
            else if (kind == 7)
            begin
                send_sample(cx, cy);
                left--;
            end
            else if (kind == 8)
            begin
                send_sample($urandom_range(0, 1) ? RAW_MAX : 0,
                            $urandom_range(0, 1) ? RAW_MAX : 0);
                left--;
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    cx = jitter(cx, 3);
                    cy = jitter(cy, 3);
                    send_sample(jitter(cx, spread), jitter(cy, spread));
                end
                left -= len;
            end
        end
    endtask

    initial
    begin
        int guard;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 16;
        recv_idle = 61;

        send_sample(0, 0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MAX, 0);
        send_sample(0, RAW_MAX);
        send_sample(RAW_MAX, RAW_MAX);
        repeat (4) send_sample(2048, 1024);
        send_sample(2049, 1023);

        program_regs('0, '0, 1'b0);
        repeat (4) send_sample(7, 9);
        send_sample(8, 9);

        program_regs('1, 16'(WEIGHT_ONE), 1'b1);
        send_sample(0, 0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(0, RAW_MAX);
        send_sample(RAW_MAX, 0);

        program_regs('1, '1, 1'b0);
        send_sample(1234, 3000);
        send_sample(3000, 1234);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 16;
                    recv_idle = 61;
                end
                1:
                begin
                    send_idle = 61;
                    recv_idle = 16;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                random_settings();
                random_samples(SEG_ITEMS);
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
